// ----- rtl/core/bspl_pkg.sv -----
// Shared types and constants for the B-spline basis evaluator.
// Used by bspl_div and bspline_basis_eval; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package bspl_pkg;

    localparam int KNOT_COUNT  = 64;
    localparam int MAX_DEGREE  = 7;
    localparam int ADDR_W      = $clog2(KNOT_COUNT);
    localparam int NB          = MAX_DEGREE + 2;
    localparam int CNT_W       = $clog2(NB + 1);
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1);

    localparam int CFG_W       = 3;
    localparam int KIDX_W      = 6;
    localparam int KNOT_W      = 32;
    localparam int BASIS_W     = 17;
    localparam int SLOPE_W     = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 56;

    localparam int NUM_W       = 50;
    localparam int DEN_W       = 32;

    localparam logic [CFG_W-1:0]   DEGREE_RESET = 3'd3;
    localparam logic [BASIS_W-1:0] Q_ONE        = 17'h10000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_RDA,
        ST_RDB,
        ST_CAP,
        ST_MUL,
        ST_DIVS,
        ST_DIVW,
        ST_RES,
        ST_DFIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_ORD0,
        PH_LEVEL,
        PH_DERIV
    } t_phase;

endpackage

`default_nettype wire

// ----- rtl/core/bspl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/bspl_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on bspl_pkg for the numerator and divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module bspl_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bspl_pkg::NUM_W-1:0]    i_num,
    input  wire logic [bspl_pkg::DEN_W-1:0]    i_den,
    input  wire logic                          i_neg,
    output logic                               o_done,
    output logic signed [bspl_pkg::NUM_W:0]    o_quot
);

    import bspl_pkg::*;

    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg;

    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [DEN_W:0]    rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_acc[NUM_W-1]};
        ge       = rem_sh >= {1'b0, r_den};
        rem_diff = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            // The numerator shifts out at the top as quotient bits shift in.
            r_acc <= {r_acc[NUM_W-2:0], ge};
            r_rem <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

endmodule

`default_nettype wire

// ----- rtl/core/bspline_basis_eval.sv -----
// Cox-de Boor B-spline basis and derivative evaluator, Q16.16 fixed point.
// Depends on bspl_pkg, bspl_ram (knot table) and bspl_div (shared divider).
// A load transaction writes one knot.
// An evaluate transaction computes order zero, then each level of weights up to the
// degree, then the derivative; the input is not ready meanwhile. Each division runs
// on the serial divider; weights on a zero basis skip it.
// Reset is synchronous and active low; it clears control state and sets degree to 3.
`timescale 1ns / 1ps
`default_nettype none

module bspline_basis_eval (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bspl_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [5:0] knot_index, [37:6] knot_value, [43:38] basis_index, [75:44] position
    input  wire logic [bspl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] kind
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [16:0] basis_value, [48:17] slope
    output logic [bspl_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [0] index_error
    output logic [0:0]                               m_axis_tuser
);

    import bspl_pkg::*;

    localparam logic signed [54:0] SAT_HI = 55'sh0_7FFF_FFFF;
    localparam logic signed [54:0] SAT_LO = -55'sh0_8000_0000;

    // Control state
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [CFG_W-1:0]   r_deg;
    logic [DEG_W-1:0]   r_k, n_k;
    logic [DEG_W-1:0]   r_l, n_l;
    logic [CNT_W-1:0]   r_m, n_m;
    logic               r_side, n_side;
    logic               r_ov;

    // Datapath
    logic [KIDX_W-1:0]     r_i;
    logic signed [31:0]    r_t;
    logic signed [31:0]    r_ka;
    logic [BASIS_W-1:0]    r_b [NB];
    logic [BASIS_W-1:0]    r_lo, r_hi;
    logic signed [32:0]    r_diff;
    logic [DEN_W-1:0]      r_den;
    logic                  r_neg;
    logic [NUM_W-1:0]      r_num;
    logic signed [NUM_W:0] r_q;
    logic signed [NUM_W:0] r_lp;
    logic signed [NUM_W:0] r_dacc;
    logic signed [31:0]    r_k0, r_kl;
    logic [BASIS_W-1:0]    r_rb, r_obasis;
    logic [SLOPE_W-1:0]    r_rs, r_oslope;
    logic                  r_re, r_oerr;

    // Input fields
    logic [KIDX_W-1:0]  in_knot_index;
    logic [KNOT_W-1:0]  in_knot_value;
    logic [KIDX_W-1:0]  in_basis_index;
    logic signed [31:0] in_position;
    logic               in_acc, in_eval, in_err;
    logic [DEG_W-1:0]   k_in;
    logic [15:0]        idx_sum;

    // Sequencer helpers
    logic [CNT_W-1:0]   step_n;
    logic               steps_left, round_done;
    logic [15:0]        addr_a_sum, addr_b_sum;
    logic [DEG_W-1:0]   span;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [KNOT_W-1:0]  ram_rdata;
    logic               ram_we;
    logic signed [31:0] kd;

    logic               cap_eq, cap_lt, in_iv;
    logic [BASIS_W-1:0] bv, dv;
    logic signed [32:0] lv_diff, span_diff;
    logic [32:0]        diff_mag;
    logic [DEN_W-1:0]   span_mag;
    logic               cap_short_lv, cap_short_dv;
    logic signed [NUM_W+1:0] lv_sum;
    logic [BASIS_W-1:0] lv_clamp;
    logic signed [54:0] dprod;
    logic [SLOPE_W-1:0] dsat;

    logic               div_start, div_done;
    logic signed [NUM_W:0] div_quot;
    logic               out_load;

    assign in_knot_index  = s_axis_tdata[5:0];
    assign in_knot_value  = s_axis_tdata[37:6];
    assign in_basis_index = s_axis_tdata[43:38];
    assign in_position    = $signed(s_axis_tdata[75:44]);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_eval       = (s_axis_tuser[0] == KIND_EVAL);

    always_comb begin
        k_in    = (int'(r_deg) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(r_deg);
        idx_sum = 16'(in_basis_index) + 16'(k_in) + 16'd1;
        in_err  = idx_sum >= 16'(KNOT_COUNT);
    end

    always_comb begin
        step_n = (r_phase == PH_ORD0) ? CNT_W'(r_k) + CNT_W'(1)
                                      : CNT_W'(r_k - r_l) + CNT_W'(1);
        steps_left = r_m < step_n;
        round_done = r_m == CNT_W'(NB);
        unique case (r_phase)
            PH_ORD0:  span = DEG_W'(1);
            PH_LEVEL: span = r_l;
            default:  span = r_k;
        endcase
        addr_a_sum = 16'(r_i) + ((r_phase == PH_DERIV) ? 16'd0 : 16'(r_m)) + 16'(r_side);
        addr_b_sum = addr_a_sum + 16'(span);
    end

    assign kd = $signed(ram_rdata);

    // Weight and derivative term selection for the capture state, level clamp and slope saturation.
    always_comb begin
        cap_eq    = (r_ka == kd);
        cap_lt    = (r_ka < kd);
        in_iv     = (r_t >= r_ka) && (r_t < kd);
        bv        = r_side ? r_b[1] : r_b[0];
        dv        = r_side ? r_hi : r_lo;
        lv_diff   = r_side ? ({kd[31], kd} - {r_t[31], r_t})
                           : ({r_t[31], r_t} - {r_ka[31], r_ka});
        span_diff = {kd[31], kd} - {r_ka[31], r_ka};
        span_mag  = span_diff[32] ? DEN_W'(-span_diff) : DEN_W'(span_diff);
        diff_mag  = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
        cap_short_lv = cap_eq || !cap_lt || (bv == '0);
        cap_short_dv = (span_diff == '0) || (dv == '0);
        lv_sum    = {r_lp[NUM_W], r_lp} + {r_q[NUM_W], r_q};
        if (lv_sum < 0) begin
            lv_clamp = '0;
        end else if (lv_sum > $signed({{(NUM_W+1-BASIS_W){1'b0}}, Q_ONE})) begin
            lv_clamp = Q_ONE;
        end else begin
            lv_clamp = lv_sum[BASIS_W-1:0];
        end
        dprod = 55'(r_dacc) * 55'($signed({1'b0, r_k}));
        if (dprod > SAT_HI) begin
            dsat = 32'h7FFF_FFFF;
        end else if (dprod < SAT_LO) begin
            dsat = 32'h8000_0000;
        end else begin
            dsat = dprod[SLOPE_W-1:0];
        end
    end

    // Next state and sequencer counters
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_k     = r_k;
        n_l     = r_l;
        n_m     = r_m;
        n_side  = r_side;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_eval) begin
                    n_k     = k_in;
                    n_m     = '0;
                    n_side  = 1'b0;
                    n_phase = PH_ORD0;
                    n_state = in_err ? ST_OUT : ST_STEP;
                end
            end
            ST_STEP: begin
                priority if (steps_left) begin
                    n_side  = 1'b0;
                    n_state = ST_RDA;
                end else if (!round_done) begin
                    n_m = r_m + 1'b1;
                end else begin
                    n_m = '0;
                    if (r_phase == PH_ORD0) begin
                        if (r_k == '0) begin
                            n_state = ST_OUT;
                        end else begin
                            n_phase = PH_LEVEL;
                            n_l     = DEG_W'(1);
                        end
                    end else if (r_l == r_k) begin
                        n_phase = PH_DERIV;
                        n_side  = 1'b0;
                        n_state = ST_RDA;
                    end else begin
                        n_l = r_l + 1'b1;
                    end
                end
            end
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_CAP;
            ST_CAP: begin
                unique case (r_phase)
                    PH_ORD0: begin
                        n_m     = r_m + 1'b1;
                        n_state = ST_STEP;
                    end
                    PH_LEVEL: n_state = cap_short_lv ? ST_RES : ST_MUL;
                    default:  n_state = cap_short_dv ? ST_RES : ST_DIVS;
                endcase
            end
            ST_MUL:  n_state = ST_DIVS;
            ST_DIVS: n_state = ST_DIVW;
            ST_DIVW: if (div_done) n_state = ST_RES;
            ST_RES: begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = ST_RDA;
                end else if (r_phase == PH_LEVEL) begin
                    n_side  = 1'b0;
                    n_m     = r_m + 1'b1;
                    n_state = ST_STEP;
                end else begin
                    n_state = ST_DFIN;
                end
            end
            ST_DFIN: n_state = ST_OUT;
            ST_OUT:  if (!r_ov || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        ram_we    = in_acc && !in_eval && (int'(in_knot_index) < KNOT_COUNT);
        ram_raddr = (r_state == ST_RDA) ? addr_a_sum[ADDR_W-1:0] : addr_b_sum[ADDR_W-1:0];
        div_start = (r_state == ST_DIVS);
        out_load  = (r_state == ST_OUT) && (!r_ov || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_ORD0;
            r_deg   <= DEGREE_RESET;
            r_k     <= '0;
            r_l     <= DEG_W'(1);
            r_m     <= '0;
            r_side  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
            r_l     <= n_l;
            r_m     <= n_m;
            r_side  <= n_side;
            if (i_cfg_we) begin
                r_deg <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_eval) begin
                    r_i  <= in_basis_index;
                    r_t  <= in_position;
                    r_rb <= '0;
                    r_rs <= '0;
                    r_re <= in_err;
                end
            end
            ST_STEP: begin
                if (!steps_left && !round_done) begin
                    // Rotate so that the values of the finished level line up at index zero.
                    for (int j = 0; j < NB - 1; j++) begin
                        r_b[j] <= r_b[j+1];
                    end
                    r_b[NB-1] <= r_b[0];
                end else if (!steps_left && round_done) begin
                    if (r_phase == PH_ORD0 && r_k == '0) begin
                        r_rb <= r_b[0];
                        r_rs <= '0;
                    end
                    if ((r_phase == PH_ORD0 && r_k == DEG_W'(1)) ||
                        (r_phase == PH_LEVEL && r_l + 1'b1 == r_k)) begin
                        r_lo <= r_b[0];
                        r_hi <= r_b[1];
                    end
                end
            end
            ST_RDB: r_ka <= kd;
            ST_CAP: begin
                unique case (r_phase)
                    PH_ORD0: begin
                        for (int j = 0; j < NB - 1; j++) begin
                            r_b[j] <= r_b[j+1];
                        end
                        r_b[NB-1] <= in_iv ? Q_ONE : '0;
                    end
                    PH_LEVEL: begin
                        r_diff <= lv_diff;
                        r_den  <= DEN_W'(span_diff);
                        r_neg  <= lv_diff[32];
                        if (cap_eq) begin
                            r_q <= r_side ? '0 : $signed({{(NUM_W+1-BASIS_W){1'b0}}, bv});
                        end else if (!cap_lt) begin
                            r_q <= r_side ? $signed({{(NUM_W+1-BASIS_W){1'b0}}, bv}) : '0;
                        end else begin
                            r_q <= '0;
                        end
                    end
                    default: begin
                        if (!r_side) begin
                            r_k0 <= r_ka;
                        end else begin
                            r_kl <= kd;
                        end
                        r_den <= span_mag;
                        r_neg <= span_diff[32];
                        r_num <= NUM_W'({dv, 16'h0000});
                        r_q   <= '0;
                    end
                endcase
            end
            ST_MUL:  r_num <= NUM_W'(diff_mag) * NUM_W'(bv);
            ST_DIVW: if (div_done) r_q <= div_quot;
            ST_RES: begin
                if (r_phase == PH_LEVEL) begin
                    if (!r_side) begin
                        r_lp <= r_q;
                    end else begin
                        for (int j = 0; j < NB - 1; j++) begin
                            r_b[j] <= r_b[j+1];
                        end
                        r_b[NB-1] <= lv_clamp;
                    end
                end else if (!r_side) begin
                    r_dacc <= r_q;
                end else begin
                    r_dacc <= r_dacc - r_q;
                end
            end
            ST_DFIN: begin
                r_rb <= r_b[0];
                r_rs <= (r_k0 == r_kl) ? '0 : dsat;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_obasis <= r_rb;
            r_oslope <= r_rs;
            r_oerr   <= r_re;
        end
    end

    bspl_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (KNOT_COUNT)
    ) u_knots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(in_knot_index)),
        .i_wdata (in_knot_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bspl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_neg   (r_neg),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_TDATA_W-BASIS_W-SLOPE_W){1'b0}}, r_oslope, r_obasis};
    assign m_axis_tuser  = r_oerr;

    a_basis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[BASIS_W-1:0] <= Q_ONE))
        else $error("basis value above one");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[BASIS_W+SLOPE_W-1:0] == '0))
        else $error("index error result carries data");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m <= CNT_W'(NB))
        else $error("step counter overran the basis row");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEVEL) |-> ((r_l <= r_k) && (r_l != '0)))
        else $error("level beyond degree");

endmodule

`default_nettype wire
